@@ rtl/ogl_pkg.sv @@
package ogl_pkg;

  localparam int unsigned COORD_W   = 10;
  localparam int unsigned GRID_W    = 1024;
  localparam int unsigned GRID_H    = 1024;
  localparam int unsigned XW        = $clog2(GRID_W);
  localparam int unsigned YW        = $clog2(GRID_H);
  localparam int unsigned LOGW      = (XW > 6) ? 6 : XW - 1;
  localparam int unsigned WORD_W    = 1 << LOGW;
  localparam int unsigned WX_W      = XW - LOGW;
  localparam int unsigned MEM_AW    = YW + WX_W;
  localparam int unsigned MEM_DEPTH = 1 << MEM_AW;
  localparam int unsigned ERR_W     = COORD_W + 3;

  typedef logic [COORD_W-1:0]      coord_t;
  typedef logic [XW-1:0]           xfull_t;
  typedef logic [YW-1:0]           yfull_t;
  typedef logic [WX_W-1:0]         wcol_t;
  typedef logic [LOGW-1:0]         bsel_t;
  typedef logic [MEM_AW-1:0]       maddr_t;
  typedef logic [WORD_W-1:0]       word_t;
  typedef logic signed [ERR_W-1:0] err_t;

  typedef enum logic [2:0] {
    REQ_BLOCK = 3'd0,
    REQ_CLEAR = 3'd1,
    REQ_MOVE  = 3'd2,
    REQ_LINE  = 3'd3,
    REQ_QUERY = 3'd4
  } req_type_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_RECT,
    OP_WALK
  } op_kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_RECT,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic clear_step;
    logic rect_step;
    logic walk_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic     clear_done;
    op_kind_t kind;
    logic     rect_last;
    logic     at_end;
    logic     hit_now;
    logic     out_free;
  } sts_t;

endpackage

@@ rtl/ogl_req_if.sv @@
interface ogl_req_if;
  logic            valid;
  logic            ready;
  logic [2:0]      req_type;
  ogl_pkg::coord_t x_a;
  ogl_pkg::coord_t y_a;
  ogl_pkg::coord_t x_b;
  ogl_pkg::coord_t y_b;

  modport source (output valid, req_type, x_a, y_a, x_b, y_b, input ready);
  modport sink (input valid, req_type, x_a, y_a, x_b, y_b, output ready);
endinterface

@@ rtl/ogl_res_if.sv @@
interface ogl_res_if;
  logic valid;
  logic ready;
  logic hit;
  logic out_of_range;

  modport source (output valid, hit, out_of_range, input ready);
  modport sink (input valid, hit, out_of_range, output ready);
endinterface

@@ rtl/ogl_ctrl.sv @@
module ogl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output ogl_pkg::cmd_t   cmd,
  input  ogl_pkg::sts_t   sts
);

  ogl_pkg::state_t state;
  ogl_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ogl_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ogl_pkg::ST_CLEAR: begin
        if (sts.clear_done) state_next = ogl_pkg::ST_IDLE;
      end
      ogl_pkg::ST_IDLE: begin
        if (in_valid) state_next = ogl_pkg::ST_SETUP;
      end
      ogl_pkg::ST_SETUP: begin
        unique case (sts.kind)
          ogl_pkg::OP_RECT: state_next = ogl_pkg::ST_RECT;
          ogl_pkg::OP_WALK: state_next = ogl_pkg::ST_WALK;
          default:          state_next = ogl_pkg::ST_FINISH;
        endcase
      end
      ogl_pkg::ST_RECT: begin
        if (sts.rect_last) state_next = ogl_pkg::ST_FINISH;
      end
      ogl_pkg::ST_WALK: begin
        priority if (sts.hit_now) begin
          state_next = ogl_pkg::ST_FINISH;
        end else if (sts.at_end) begin
          state_next = ogl_pkg::ST_DRAIN;
        end
      end
      ogl_pkg::ST_DRAIN: begin
        state_next = ogl_pkg::ST_FINISH;
      end
      ogl_pkg::ST_FINISH: begin
        if (sts.out_free) state_next = ogl_pkg::ST_IDLE;
      end
      default: state_next = ogl_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    unique case (state)
      ogl_pkg::ST_CLEAR:  cmd.clear_step = 1'b1;
      ogl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ogl_pkg::ST_SETUP:  cmd.setup     = 1'b1;
      ogl_pkg::ST_RECT:   cmd.rect_step = 1'b1;
      ogl_pkg::ST_WALK:   cmd.walk_step = !sts.hit_now;
      ogl_pkg::ST_DRAIN:  cmd           = '0;
      ogl_pkg::ST_FINISH: cmd.finish    = sts.out_free;
      default:            cmd           = '0;
    endcase
  end

endmodule

@@ rtl/ogl_dp.sv @@
module ogl_dp (
  input  logic            clk,
  input  logic            rst,
  input  ogl_pkg::cmd_t   cmd,
  output ogl_pkg::sts_t   sts,
  input  logic [2:0]      req_type,
  input  ogl_pkg::coord_t x_a,
  input  ogl_pkg::coord_t y_a,
  input  ogl_pkg::coord_t x_b,
  input  ogl_pkg::coord_t y_b,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_hit,
  output logic            out_oor
);

  function automatic ogl_pkg::wcol_t word_of(ogl_pkg::coord_t x);
    ogl_pkg::xfull_t xf;
    xf = ogl_pkg::xfull_t'(x);
    return xf[ogl_pkg::XW-1:ogl_pkg::LOGW];
  endfunction

  function automatic ogl_pkg::bsel_t bit_of(ogl_pkg::coord_t x);
    return x[ogl_pkg::LOGW-1:0];
  endfunction

  ogl_pkg::word_t mem [0:ogl_pkg::MEM_DEPTH-1];

  // request registers
  ogl_pkg::op_kind_t kind;
  logic              oor;
  logic              fill_val;
  logic              hit;
  ogl_pkg::coord_t   x0, y0, x1, y1;

  // walker and rectangle cursor
  ogl_pkg::coord_t   cur_x, cur_y;
  ogl_pkg::wcol_t    rw;
  ogl_pkg::err_t     dx, dy, err;
  logic              sx_neg, sy_neg;

  // memory side
  ogl_pkg::maddr_t   clr_addr;
  ogl_pkg::word_t    rd_word;
  ogl_pkg::bsel_t    bit_sel;
  logic              rd_pend;

  // load decode
  ogl_pkg::coord_t   xlo, xhi, ylo, yhi;
  logic              oor_a, oor_b;
  ogl_pkg::op_kind_t ld_kind;
  logic              ld_oor;
  ogl_pkg::coord_t   ld_x0, ld_y0, ld_x1, ld_y1;

  // step logic
  ogl_pkg::err_t     e2;
  logic              step_x, step_y;
  ogl_pkg::err_t     err_next;
  ogl_pkg::word_t    wr_mask;
  ogl_pkg::maddr_t   wr_addr;
  logic              wr_en;
  logic              wr_val;
  ogl_pkg::maddr_t   rd_addr;
  logic              hit_now;

  always_comb begin
    xlo   = (x_a < x_b) ? x_a : x_b;
    xhi   = (x_a < x_b) ? x_b : x_a;
    ylo   = (y_a < y_b) ? y_a : y_b;
    yhi   = (y_a < y_b) ? y_b : y_a;
    oor_a = (32'(x_a) >= ogl_pkg::GRID_W) || (32'(y_a) >= ogl_pkg::GRID_H);
    oor_b = (32'(x_b) >= ogl_pkg::GRID_W) || (32'(y_b) >= ogl_pkg::GRID_H);
    ld_kind = ogl_pkg::OP_NONE;
    ld_oor  = 1'b0;
    ld_x0   = x_a;
    ld_y0   = y_a;
    ld_x1   = x_a;
    ld_y1   = y_a;
    unique case (req_type)
      ogl_pkg::REQ_BLOCK, ogl_pkg::REQ_CLEAR: begin
        ld_oor  = oor_a || oor_b;
        ld_kind = ld_oor ? ogl_pkg::OP_NONE : ogl_pkg::OP_RECT;
        ld_x0   = xlo;
        ld_y0   = ylo;
        ld_x1   = xhi;
        ld_y1   = yhi;
      end
      ogl_pkg::REQ_MOVE: begin
        ld_oor  = oor_a || oor_b;
        ld_kind = ld_oor ? ogl_pkg::OP_NONE : ogl_pkg::OP_WALK;
        if (x_a == x_b) begin
          ld_y0 = ylo;
          ld_y1 = yhi;
        end else begin
          ld_x0 = xlo;
          ld_x1 = xhi;
        end
      end
      ogl_pkg::REQ_LINE: begin
        ld_oor  = oor_a || oor_b;
        ld_kind = ld_oor ? ogl_pkg::OP_NONE : ogl_pkg::OP_WALK;
        ld_x1   = x_b;
        ld_y1   = y_b;
      end
      ogl_pkg::REQ_QUERY: begin
        ld_oor  = oor_a;
        ld_kind = ld_oor ? ogl_pkg::OP_NONE : ogl_pkg::OP_WALK;
      end
      default: ld_kind = ogl_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind     <= ld_kind;
      oor      <= ld_oor;
      fill_val <= (req_type == ogl_pkg::REQ_BLOCK);
      x0       <= ld_x0;
      y0       <= ld_y0;
      x1       <= ld_x1;
      y1       <= ld_y1;
    end
  end

  always_comb begin
    e2       = err <<< 1;
    step_x   = (e2 >= dy);
    step_y   = (e2 <= dx);
    err_next = err + (step_x ? dy : '0) + (step_y ? dx : '0);
  end

  always_ff @(posedge clk) begin
    priority if (cmd.setup) begin
      cur_x  <= x0;
      cur_y  <= y0;
      rw     <= word_of(x0);
      dx     <= ogl_pkg::err_t'((x1 > x0) ? x1 - x0 : x0 - x1);
      dy     <= -ogl_pkg::err_t'((y1 > y0) ? y1 - y0 : y0 - y1);
      err    <= ogl_pkg::err_t'((x1 > x0) ? x1 - x0 : x0 - x1)
              - ogl_pkg::err_t'((y1 > y0) ? y1 - y0 : y0 - y1);
      sx_neg <= !(x0 < x1);
      sy_neg <= !(y0 < y1);
    end else if (cmd.walk_step) begin
      err <= err_next;
      if (step_x) cur_x <= sx_neg ? cur_x - 1'b1 : cur_x + 1'b1;
      if (step_y) cur_y <= sy_neg ? cur_y - 1'b1 : cur_y + 1'b1;
    end else if (cmd.rect_step) begin
      if (rw == word_of(x1)) begin
        rw    <= word_of(x0);
        cur_y <= cur_y + 1'b1;
      end else begin
        rw <= rw + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_comb begin
    ogl_pkg::xfull_t col;
    for (int i = 0; i < ogl_pkg::WORD_W; i++) begin
      col        = {rw, ogl_pkg::bsel_t'(i)};
      wr_mask[i] = cmd.clear_step ||
                   ((col >= ogl_pkg::xfull_t'(x0)) && (col <= ogl_pkg::xfull_t'(x1)));
    end
    wr_en   = cmd.clear_step || cmd.rect_step;
    wr_val  = cmd.rect_step && fill_val;
    wr_addr = cmd.clear_step ? clr_addr : {ogl_pkg::yfull_t'(cur_y), rw};
    rd_addr = {ogl_pkg::yfull_t'(cur_y), word_of(cur_x)};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < ogl_pkg::WORD_W; i++) begin
        if (wr_mask[i]) mem[wr_addr][i] <= wr_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_step) begin
      rd_word <= mem[rd_addr];
      bit_sel <= bit_of(cur_x);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.walk_step;
    end
  end

  assign hit_now = rd_pend && rd_word[bit_sel];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit <= 1'b0;
    end else if (hit_now) begin
      hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_hit <= hit;
      out_oor <= oor;
    end
  end

  always_comb begin
    sts.clear_done = (clr_addr == ogl_pkg::maddr_t'(ogl_pkg::MEM_DEPTH - 1));
    sts.kind       = kind;
    sts.rect_last  = (rw == word_of(x1)) && (cur_y == y1);
    sts.at_end     = (cur_x == x1) && (cur_y == y1);
    sts.hit_now    = hit_now;
    sts.out_free   = !out_valid || out_ready;
  end

endmodule

@@ rtl/occupancy_grid_line_check.sv @@
// Occupancy grid with rectangle writes, path checks and pixel queries.
// Channel req takes one request word (req_type, x_a, y_a, x_b, y_b); channel
// res returns exactly one word (hit, out_of_range) per request, in order.
// The bitmap sits in one memory of 64-bit words, one masked write or one
// read per cycle; that port sets the pace of each request:
//   rectangle write: one masked write per word spanned, row by row
//   move, line of sight: one read per pixel walked, ending early on a hit
//   pixel query: a single read; out of range or unknown type: no access
// A request is taken only when the previous one has left the datapath.
// After reset the block sweeps the bitmap clear, one word per cycle, over
// all 16384 words at the default grid size; req.ready stays low until done.
// The result sits in an output register: a stalled receiver does not block
// the next request, which runs and then waits for the register to drain.
module occupancy_grid_line_check (
  input  logic       clk,
  input  logic       rst,
  ogl_req_if.sink    req,
  ogl_res_if.source  res
);

  ogl_pkg::cmd_t cmd;
  ogl_pkg::sts_t sts;

  ogl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  ogl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_type  (req.req_type),
    .x_a       (req.x_a),
    .y_a       (req.y_a),
    .x_b       (req.x_b),
    .y_b       (req.y_b),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_hit   (res.hit),
    .out_oor   (res.out_of_range)
  );

endmodule
